### rtl/swp_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the spot-weld pulse sequencer.
// No dependencies; every other file takes names from here by scope.
package swp_pkg;

   // Sequence phases, in the order the sequence walks through them
   typedef enum logic [2:0] {
      PH_IDLE    = 3'd0,
      PH_CONFIRM = 3'd1,
      PH_PRE     = 3'd2,
      PH_PAUSE   = 3'd3,
      PH_MAIN    = 3'd4,
      PH_HOLD    = 3'd5,
      PH_RWAIT   = 3'd6,
      PH_RCONF   = 3'd7
   } seq_phase_type;

   // Configuration register indexes (byte address is 4 times the index)
   typedef enum logic [2:0] {
      CSR_PRE_PULSE  = 3'd0,
      CSR_PAUSE      = 3'd1,
      CSR_MAIN_PULSE = 3'd2,
      CSR_HOLD       = 3'd3,
      CSR_LOCKOUT    = 3'd4,
      CSR_FAN        = 3'd5,
      CSR_SPARE_6    = 3'd6,
      CSR_SPARE_7    = 3'd7
   } csr_index_type;

   localparam int unsigned ADDR_W = 5;
   localparam int unsigned DATA_W = 32;

   localparam int unsigned REQ_TDATA_W = 16;
   localparam int unsigned RSP_TDATA_W = 8;
   localparam int unsigned TEMP_W      = 12;
   localparam int unsigned WHOLE_W     = 8;

   // Ticks the release must still hold before the buzzer turns off
   localparam logic [7:0] RELEASE_CONFIRM_TICKS = 8'd10;

   localparam int unsigned QUEUE_DEPTH = 2;

   // Register reset values
   localparam logic [6:0] PRE_PULSE_RESET  = 7'd5;
   localparam logic [6:0] PAUSE_RESET      = 7'd10;
   localparam logic [7:0] MAIN_PULSE_RESET = 8'd10;
   localparam logic [7:0] HOLD_RESET       = 8'd50;
   localparam logic [6:0] LOCKOUT_RESET    = 7'd60;
   localparam logic [6:0] FAN_RESET        = 7'd30;

   // One tick after classification
   typedef struct packed {
      logic button;
      logic allowed;
      logic fan;
   } tick_item_type;

   // Sequencer settings handed to the back end
   typedef struct packed {
      logic [6:0] pre_pulse;
      logic [6:0] pause;
      logic [7:0] main_pulse;
      logic [7:0] hold;
   } seq_cfg_type;

   // Status of the back end, watched by the top level
   typedef struct packed {
      seq_phase_type phase;
      logic          busy;
   } back_status_type;

endpackage

### rtl/swp_front.sv
`timescale 1ns / 1ps
// Front end: takes a tick transaction and classifies the temperature.
// Depends on swp_pkg.
module swp_front (
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   input  logic [swp_pkg::REQ_TDATA_W-1:0]      req_tdata,
   input  logic                                 queue_full,
   input  logic [6:0]                           lockout_temp,
   input  logic [6:0]                           fan_temp,
   output logic                                 req_tready,
   output logic                                 push,
   output swp_pkg::tick_item_type               push_item
);

   logic signed [swp_pkg::TEMP_W-1:0]  temp_raw;
   logic signed [swp_pkg::WHOLE_W-1:0] whole_floor;
   logic signed [swp_pkg::WHOLE_W-1:0] whole;
   logic signed [swp_pkg::WHOLE_W:0]   whole_x;
   logic signed [swp_pkg::WHOLE_W:0]   lockout_x;
   logic signed [swp_pkg::WHOLE_W:0]   fan_x;
   logic                               round_up;

   // The queue carries the back pressure; no state of its own here
   assign req_tready = ~queue_full & ~reset;
   assign push       = req_tvalid & req_tready;

   assign temp_raw    = req_tdata[swp_pkg::TEMP_W:1];
   assign whole_floor = temp_raw[swp_pkg::TEMP_W-1:4];
   // Truncate toward zero: bump negative values that carry a fraction
   assign round_up    = temp_raw[swp_pkg::TEMP_W-1] & (|temp_raw[3:0]);
   assign whole       = whole_floor + $signed({{(swp_pkg::WHOLE_W-1){1'b0}}, round_up});

   assign whole_x   = {whole[swp_pkg::WHOLE_W-1], whole};
   assign lockout_x = $signed({2'b00, lockout_temp});
   assign fan_x     = $signed({2'b00, fan_temp});

   always_comb begin
      push_item.button  = req_tdata[0];
      push_item.allowed = whole_x < lockout_x;
      push_item.fan     = whole_x >= fan_x;
   end

endmodule

### rtl/swp_queue.sv
`timescale 1ns / 1ps
// Short queue of classified ticks between front and back ends.
// Depends on swp_pkg.
module swp_queue #(
   parameter int unsigned DEPTH = swp_pkg::QUEUE_DEPTH
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  swp_pkg::tick_item_type  push_item,
   input  logic                    pop,
   output logic                    full,
   output logic                    not_empty,
   output swp_pkg::tick_item_type  head_item
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   swp_pkg::tick_item_type store_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
      logic [PTR_W-1:0] r;
      if (p == PTR_W'(DEPTH - 1)) begin
         r = '0;
      end else begin
         r = p + PTR_W'(1);
      end
      return r;
   endfunction

   assign full      = count_ff == CNT_W'(DEPTH);
   assign not_empty = count_ff != '0;
   assign head_item = store_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ptr_next(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? ptr_next(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         store_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

### rtl/swp_back.sv
`timescale 1ns / 1ps
// Back end: phase sequencer and registered result transaction.
// Depends on swp_pkg.
module swp_back (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                item_valid,
   input  swp_pkg::tick_item_type              item,
   input  swp_pkg::seq_cfg_type                cfg,
   input  logic                                rsp_tready,
   output logic                                pop,
   output logic                                rsp_tvalid,
   output logic [swp_pkg::RSP_TDATA_W-1:0]     rsp_tdata,
   output swp_pkg::back_status_type            status
);

   swp_pkg::seq_phase_type phase_ff, phase_in;
   logic [7:0] ticks_ff, ticks_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic [swp_pkg::RSP_TDATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic [7:0] len_cur;
   logic [7:0] ticks_inc;
   swp_pkg::seq_phase_type next_timed;
   swp_pkg::seq_phase_type tgt_pre;
   swp_pkg::seq_phase_type tgt_next;
   logic [3:0] zero_len;

   // Land on the first phase from start on whose length is not zero
   function automatic swp_pkg::seq_phase_type skip_zero(
      input swp_pkg::seq_phase_type start,
      input logic [3:0]             z
   );
      swp_pkg::seq_phase_type p;
      p = swp_pkg::PH_RWAIT;
      if (start <= swp_pkg::PH_HOLD && !z[3]) p = swp_pkg::PH_HOLD;
      if (start <= swp_pkg::PH_MAIN && !z[2]) p = swp_pkg::PH_MAIN;
      if (start <= swp_pkg::PH_PAUSE && !z[1]) p = swp_pkg::PH_PAUSE;
      if (start <= swp_pkg::PH_PRE && !z[0]) p = swp_pkg::PH_PRE;
      return p;
   endfunction

   assign zero_len = {cfg.hold == '0, cfg.main_pulse == '0,
                      cfg.pause == '0, cfg.pre_pulse == '0};

   assign pop        = item_valid & (~rsp_valid_ff | rsp_tready);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_comb begin
      status.phase = phase_ff;
      status.busy  = phase_ff != swp_pkg::PH_IDLE;
   end

   always_comb begin
      case (phase_ff)
         swp_pkg::PH_PRE:   len_cur = {1'b0, cfg.pre_pulse};
         swp_pkg::PH_PAUSE: len_cur = {1'b0, cfg.pause};
         swp_pkg::PH_MAIN:  len_cur = cfg.main_pulse;
         swp_pkg::PH_HOLD:  len_cur = cfg.hold;
         default:           len_cur = '0;
      endcase
   end

   assign ticks_inc  = (ticks_ff == 8'hFF) ? ticks_ff : ticks_ff + 8'd1;
   assign next_timed = swp_pkg::seq_phase_type'(phase_ff + 3'd1);
   assign tgt_pre    = skip_zero(swp_pkg::PH_PRE, zero_len);
   assign tgt_next   = skip_zero(next_timed, zero_len);

   always_comb begin
      phase_in = phase_ff;
      ticks_in = ticks_ff;
      case (phase_ff)
         swp_pkg::PH_IDLE: begin
            if (item.button) begin
               phase_in = swp_pkg::PH_CONFIRM;
               ticks_in = '0;
            end
         end
         swp_pkg::PH_CONFIRM: begin
            if (item.button && item.allowed) begin
               phase_in = tgt_pre;
               ticks_in = (tgt_pre != swp_pkg::PH_RWAIT) ? 8'd1 : 8'd0;
            end else begin
               phase_in = swp_pkg::PH_IDLE;
               ticks_in = '0;
            end
         end
         swp_pkg::PH_PRE, swp_pkg::PH_PAUSE, swp_pkg::PH_MAIN, swp_pkg::PH_HOLD: begin
            if (ticks_ff >= len_cur) begin
               phase_in = tgt_next;
               ticks_in = (tgt_next != swp_pkg::PH_RWAIT) ? 8'd1 : 8'd0;
            end else begin
               ticks_in = ticks_inc;
            end
         end
         swp_pkg::PH_RWAIT: begin
            if (!item.button) begin
               phase_in = swp_pkg::PH_RCONF;
               ticks_in = '0;
            end
         end
         swp_pkg::PH_RCONF: begin
            ticks_in = ticks_inc;
            if (ticks_inc >= swp_pkg::RELEASE_CONFIRM_TICKS) begin
               phase_in = item.button ? swp_pkg::PH_RWAIT : swp_pkg::PH_IDLE;
               ticks_in = '0;
            end
         end
         default: begin
            phase_in = swp_pkg::PH_IDLE;
            ticks_in = '0;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (pop) begin
         rsp_valid_in   = 1'b1;
         rsp_data_in[0] = (phase_in == swp_pkg::PH_PRE) || (phase_in == swp_pkg::PH_MAIN);
         rsp_data_in[1] = phase_in >= swp_pkg::PH_HOLD;
         rsp_data_in[2] = item.fan;
         rsp_data_in[3] = item.allowed;
         rsp_data_in[6:4] = phase_in;
         rsp_data_in[7] = 1'b0;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= swp_pkg::PH_IDLE;
         ticks_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (pop) begin
            phase_ff <= phase_in;
            ticks_ff <= ticks_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

endmodule

### rtl/spot_weld_pulse_sequencer.sv
`timescale 1ns / 1ps
// Spot-weld pulse sequencer top level: register block, front, queue, back.
// Depends on swp_pkg, swp_front, swp_queue and swp_back.

// One request transaction is one 10 ms tick: the weld button level and a raw
// temperature in 1/16 degree. Every tick yields exactly one response carrying
// the weld drive, buzzer, fan and weld-allowed levels and the sequence phase
// after the tick. The block takes one tick per clock cycle when the response
// side keeps up; an accepted tick is stored in the queue and its response is
// then registered in the response register before it is presented. The front
// end classifies the temperature (whole degrees, truncated toward zero,
// against the lockout and fan thresholds) and pushes the tick into a short
// queue; the back end pops it, advances the phase sequencer and registers
// the response, so a stalled response does not stop the next request until
// the queue has filled. Write the six settings registers over the APB port
// only while no tick is in flight.
module spot_weld_pulse_sequencer #(
   parameter int unsigned QUEUE_DEPTH = swp_pkg::QUEUE_DEPTH
) (
   input  logic                              clock,
   input  logic                              reset,
   // Request transaction
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // [0] button_pressed, [12:1] temp_raw, [15:13] zero
   input  logic [swp_pkg::REQ_TDATA_W-1:0]   req_tdata,
   // Response transaction
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // [0] weld_drive, [1] buzzer_on, [2] fan_on, [3] weld_allowed,
   // [6:4] phase, [7] zero
   output logic [swp_pkg::RSP_TDATA_W-1:0]   rsp_tdata,
   // Settings registers
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [swp_pkg::ADDR_W-1:0]        csr_paddr,
   input  logic [swp_pkg::DATA_W-1:0]        csr_pwdata,
   output logic [swp_pkg::DATA_W-1:0]        csr_prdata,
   output logic                              csr_pready
);

   logic [6:0] pre_pulse_ff;
   logic [6:0] pause_ff;
   logic [7:0] main_pulse_ff;
   logic [7:0] hold_ff;
   logic [6:0] lockout_ff;
   logic [6:0] fan_ff;

   swp_pkg::csr_index_type csr_index;
   logic                   csr_write;

   logic                     queue_full;
   logic                     queue_not_empty;
   logic                     push;
   logic                     pop;
   swp_pkg::tick_item_type   push_item;
   swp_pkg::tick_item_type   head_item;
   swp_pkg::seq_cfg_type     seq_cfg;
   swp_pkg::back_status_type back_status;

   // Register block: zero wait states, index from the word address
   assign csr_pready = 1'b1;
   assign csr_index  = swp_pkg::csr_index_type'(csr_paddr[swp_pkg::ADDR_W-1:2]);
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         pre_pulse_ff  <= swp_pkg::PRE_PULSE_RESET;
         pause_ff      <= swp_pkg::PAUSE_RESET;
         main_pulse_ff <= swp_pkg::MAIN_PULSE_RESET;
         hold_ff       <= swp_pkg::HOLD_RESET;
         lockout_ff    <= swp_pkg::LOCKOUT_RESET;
         fan_ff        <= swp_pkg::FAN_RESET;
      end else if (csr_write) begin
         case (csr_index)
            swp_pkg::CSR_PRE_PULSE:  pre_pulse_ff  <= csr_pwdata[6:0];
            swp_pkg::CSR_PAUSE:      pause_ff      <= csr_pwdata[6:0];
            swp_pkg::CSR_MAIN_PULSE: main_pulse_ff <= csr_pwdata[7:0];
            swp_pkg::CSR_HOLD:       hold_ff       <= csr_pwdata[7:0];
            swp_pkg::CSR_LOCKOUT:    lockout_ff    <= csr_pwdata[6:0];
            swp_pkg::CSR_FAN:        fan_ff        <= csr_pwdata[6:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         swp_pkg::CSR_PRE_PULSE:  csr_prdata = {25'd0, pre_pulse_ff};
         swp_pkg::CSR_PAUSE:      csr_prdata = {25'd0, pause_ff};
         swp_pkg::CSR_MAIN_PULSE: csr_prdata = {24'd0, main_pulse_ff};
         swp_pkg::CSR_HOLD:       csr_prdata = {24'd0, hold_ff};
         swp_pkg::CSR_LOCKOUT:    csr_prdata = {25'd0, lockout_ff};
         swp_pkg::CSR_FAN:        csr_prdata = {25'd0, fan_ff};
         default:                 csr_prdata = '0;
      endcase
   end

   always_comb begin
      seq_cfg.pre_pulse  = pre_pulse_ff;
      seq_cfg.pause      = pause_ff;
      seq_cfg.main_pulse = main_pulse_ff;
      seq_cfg.hold       = hold_ff;
   end

   // Classify each tick as it arrives
   swp_front u_front (
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tdata    (req_tdata),
      .queue_full   (queue_full),
      .lockout_temp (lockout_ff),
      .fan_temp     (fan_ff),
      .req_tready   (req_tready),
      .push         (push),
      .push_item    (push_item)
   );

   // Hold classified ticks while the response side stalls
   swp_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .full      (queue_full),
      .not_empty (queue_not_empty),
      .head_item (head_item)
   );

   // Advance the phase sequencer, one tick per pop
   swp_back u_back (
      .clock      (clock),
      .reset      (reset),
      .item_valid (queue_not_empty),
      .item       (head_item),
      .cfg        (seq_cfg),
      .rsp_tready (rsp_tready),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata),
      .status     (back_status)
   );

`ifndef SYNTHESIS
   // From idle the sequencer may only stay or move to confirm
   a_idle_exit : assert property (@(posedge clock) disable iff (reset)
      (back_status.phase == swp_pkg::PH_IDLE) |=>
      (back_status.phase == swp_pkg::PH_IDLE || back_status.phase == swp_pkg::PH_CONFIRM))
      else $error("sequencer left idle for a phase other than confirm");

   // Release wait only moves on to release confirm
   a_rwait_exit : assert property (@(posedge clock) disable iff (reset)
      (back_status.phase == swp_pkg::PH_RWAIT) |=>
      (back_status.phase == swp_pkg::PH_RWAIT || back_status.phase == swp_pkg::PH_RCONF))
      else $error("sequencer left release wait for a phase other than release confirm");

   // A taken response with nothing queued leaves the response register empty
   a_rsp_drain : assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && !queue_not_empty) |=> !rsp_tvalid)
      else $error("response presented without a queued tick");
`endif

endmodule
